// ===== hw/rtl/tuww_pkg.sv =====
// types, constants and character classification shared by the word wrapper
package tuww_pkg;

   localparam int BYTE_W      = 8;
   localparam int CNT_W       = 6;
   localparam int LINE_W      = 9;
   localparam int SUM_W       = LINE_W + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] CHAR_SPACE       = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_TAB         = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_CR          = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_HYPHEN      = 8'h2D;
   localparam logic [BYTE_W-1:0] CASE_OFFSET      = 8'h20;
   localparam logic [BYTE_W-1:0] LINE_WIDTH_RESET = 8'd72;

   typedef enum logic [1:0] {
      MODE_START,
      MODE_GAP,
      MODE_WORD
   } scan_mode_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_DECIDE,
      BACK_FETCH,
      BACK_CHAR,
      BACK_SPACE,
      BACK_EOL
   } back_state_type;

   typedef struct packed {
      logic              bank;
      logic [CNT_W-1:0]  stored_count;
      logic [CNT_W-1:0]  letter_count;
      logic              end_of_text;
   } cmd_type;

   function automatic logic is_space(input logic [BYTE_W-1:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   function automatic logic is_alpha(input logic [BYTE_W-1:0] b);
      return ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
   endfunction

   function automatic logic starts_word(input logic [BYTE_W-1:0] b);
      return is_alpha(b) || ((b >= "0") && (b <= "9")) || (b == CHAR_HYPHEN);
   endfunction

   // zero means the byte is dropped
   function automatic logic [BYTE_W-1:0] map_char(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] m;
      m = '0;
      if ((b >= "A") && (b <= "Z")) begin
         m = b;
      end else if ((b >= "a") && (b <= "z")) begin
         m = b - CASE_OFFSET;
      end else begin
         case (b)
            8'hE9, 8'hC9, 8'hE8, 8'hC8, 8'hEA, 8'hCA, 8'hEB: m = "E";
            8'hE0, 8'hC0, 8'hE2, 8'hC2, 8'hE1:               m = "A";
            8'hE7, 8'hC7:                                    m = "C";
            8'hD4, 8'hF4:                                    m = "O";
            8'hF9, 8'hFB:                                    m = "U";
            8'hEE:                                           m = "I";
            default:                                         m = '0;
         endcase
      end
      return m;
   endfunction

endpackage

// ===== hw/rtl/tuww_if.sv =====
// valid/ready stream interfaces for text bytes in and wrapped bytes out
interface tuww_req_if
   import tuww_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface tuww_rsp_if
   import tuww_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== hw/rtl/tuww_ram.sv =====
// generic simple dual-port ram with registered read
module tuww_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/tuww_front.sv =====
// front end: scans input bytes, fills the word buffer, queues word flushes
module tuww_front
   import tuww_pkg::*;
#(
   parameter int WORD_MAX = 61,
   parameter int ADDR_W   = 7
) (
   input  logic              clock,
   input  logic              reset,
   tuww_req_if.sink          req,
   input  logic              room,
   output logic              cmd_push,
   output cmd_type           cmd,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [BYTE_W-1:0] wr_data
);
   scan_mode_type    mode_ff, mode_in;
   logic [CNT_W-1:0] stored_ff, stored_in;
   logic [CNT_W-1:0] letters_ff, letters_in;
   logic             bank_ff, bank_in;
   logic             accept;
   logic             take;
   logic [BYTE_W-1:0] mapped;

   assign req.ready = room;
   assign accept    = req.valid && req.ready;
   assign mapped    = map_char(req.in_byte);

   always_comb begin
      mode_in    = mode_ff;
      stored_in  = stored_ff;
      letters_in = letters_ff;
      bank_in    = bank_ff;
      cmd_push   = 1'b0;
      take       = 1'b0;
      wr_en      = 1'b0;
      if (accept) begin
         if (req.end_of_text) begin
            cmd_push   = 1'b1;
            bank_in    = !bank_ff;
            stored_in  = '0;
            letters_in = '0;
            mode_in    = MODE_START;
         end else begin
            case (mode_ff)
               MODE_WORD: begin
                  if (is_space(req.in_byte)) begin
                     if (letters_ff != '0) begin
                        cmd_push = 1'b1;
                        bank_in  = !bank_ff;
                     end
                     stored_in  = '0;
                     letters_in = '0;
                     mode_in    = MODE_GAP;
                  end else begin
                     take = 1'b1;
                  end
               end
               MODE_GAP: begin
                  if (starts_word(req.in_byte)) begin
                     mode_in = MODE_WORD;
                     take    = 1'b1;
                  end
               end
               MODE_START: begin
                  if (!is_space(req.in_byte)) begin
                     mode_in = MODE_WORD;
                     take    = 1'b1;
                  end
               end
               default: begin
                  mode_in = MODE_START;
               end
            endcase
            if (take && (mapped != '0) && (stored_ff < CNT_W'(WORD_MAX))) begin
               wr_en      = 1'b1;
               stored_in  = stored_ff + CNT_W'(1);
               letters_in = letters_ff + {{(CNT_W-1){1'b0}}, is_alpha(req.in_byte)};
            end
         end
      end
   end

   assign wr_addr = bank_ff ? ADDR_W'(WORD_MAX) + ADDR_W'(stored_ff) : ADDR_W'(stored_ff);
   assign wr_data = mapped;

   assign cmd.bank         = bank_ff;
   assign cmd.stored_count = stored_ff;
   assign cmd.letter_count = letters_ff;
   assign cmd.end_of_text  = req.end_of_text;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_START;
         stored_ff  <= '0;
         letters_ff <= '0;
         bank_ff    <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         stored_ff  <= stored_in;
         letters_ff <= letters_in;
         bank_ff    <= bank_in;
      end
   end
endmodule

// ===== hw/rtl/tuww_cmd_queue.sv =====
// two-entry queue of word flush commands between front and back ends
module tuww_cmd_queue
   import tuww_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cmd_type            push_cmd,
   input  logic               pop,
   output cmd_type            head,
   output logic               not_empty,
   output logic [LEVEL_W-1:0] level
);
   cmd_type            slot_ff [QUEUE_DEPTH];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + LEVEL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (level_ff != '0);
   assign level     = level_ff;
endmodule

// ===== hw/rtl/tuww_back.sv =====
// back end: greedy line fill decision and byte-by-byte output of each word
module tuww_back
   import tuww_pkg::*;
#(
   parameter int WORD_MAX = 61,
   parameter int ADDR_W   = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] line_width,
   input  cmd_type           head,
   input  logic              not_empty,
   output logic              pop,
   output logic              busy,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [BYTE_W-1:0] rd_data,
   tuww_rsp_if.source        rsp
);
   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              out_free;
   logic              wrap;
   logic              last_char;
   logic              load;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign wrap      = (line_ff != '0) &&
                      ((SUM_W'(line_ff) + SUM_W'(cmd_ff.letter_count)) > SUM_W'(line_width));
   assign last_char = ((idx_ff + CNT_W'(1)) == cmd_ff.stored_count);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (not_empty) begin
               state_in = BACK_DECIDE;
            end
         end
         BACK_DECIDE: begin
            if (cmd_ff.letter_count == '0) begin
               state_in = BACK_EOL;
            end else if (!wrap || out_free) begin
               state_in = BACK_FETCH;
            end
         end
         BACK_FETCH: begin
            state_in = BACK_CHAR;
         end
         BACK_CHAR: begin
            if (out_free) begin
               state_in = last_char ? BACK_SPACE : BACK_FETCH;
            end
         end
         BACK_SPACE: begin
            if (out_free) begin
               state_in = cmd_ff.end_of_text ? BACK_EOL : BACK_IDLE;
            end
         end
         BACK_EOL: begin
            if (out_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop         = 1'b0;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      line_in     = line_ff;
      rd_en       = 1'b0;
      load        = 1'b0;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (not_empty) begin
               pop    = 1'b1;
               cmd_in = head;
            end
         end
         BACK_DECIDE: begin
            idx_in = '0;
            if (cmd_ff.letter_count != '0) begin
               if (wrap) begin
                  if (out_free) begin
                     load        = 1'b1;
                     rsp_byte_in = CHAR_NEWLINE;
                     rsp_last_in = 1'b0;
                     line_in     = LINE_W'(cmd_ff.letter_count);
                  end
               end else begin
                  line_in = line_ff + LINE_W'(cmd_ff.letter_count) + LINE_W'(1);
               end
            end
         end
         BACK_FETCH: begin
            rd_en = 1'b1;
         end
         BACK_CHAR: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_byte_in = rd_data;
               rsp_last_in = 1'b0;
               idx_in      = idx_ff + CNT_W'(1);
            end
         end
         BACK_SPACE: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_byte_in = CHAR_SPACE;
               rsp_last_in = !cmd_ff.end_of_text;
            end
         end
         BACK_EOL: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_byte_in = CHAR_NEWLINE;
               rsp_last_in = 1'b1;
               line_in     = '0;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rd_addr = cmd_ff.bank ? ADDR_W'(WORD_MAX) + ADDR_W'(idx_ff) : ADDR_W'(idx_ff);
   assign busy    = (state_ff != BACK_IDLE);

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= BACK_IDLE;
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = rsp_byte_ff;
   assign rsp.last_of_run = rsp_last_ff;
endmodule

// ===== hw/rtl/text_upcase_word_wrapper_core.sv =====
// upper-casing greedy word wrapper, top level
// a byte inside a word or a gap is taken in one cycle; the front stalls only
// while two word flushes are outstanding (both word buffer banks in use)
// a flushed word with letters leaves one stored character at a time, each read
// from the registered word buffer before it is sent, after a decision and before a space
// synchronous active-high reset: line width 72, line count zero, start mode
module text_upcase_word_wrapper_core
   import tuww_pkg::*;
#(
   parameter int WORD_MAX = 61
) (
   input  logic              clock,
   input  logic              reset,
   tuww_req_if.sink          req,
   tuww_rsp_if.source        rsp,
   input  logic              csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data
);
   localparam int RAM_DEPTH = 2 * WORD_MAX;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);

   logic [BYTE_W-1:0]  line_width_ff;
   logic               room;
   logic               cmd_push;
   cmd_type            cmd;
   cmd_type            head;
   logic               not_empty;
   logic [LEVEL_W-1:0] level;
   logic               pop;
   logic               busy;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [BYTE_W-1:0]  wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0]  rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
      end else if (csr_wr_en) begin
         line_width_ff <= csr_wr_data;
      end
   end

   // each outstanding flush holds one buffer bank
   assign room = (level == '0) || ((level == LEVEL_W'(1)) && !busy);

   tuww_front #(
      .WORD_MAX (WORD_MAX),
      .ADDR_W   (ADDR_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .room     (room),
      .cmd_push (cmd_push),
      .cmd      (cmd),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   tuww_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (cmd),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .level     (level)
   );

   tuww_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tuww_back #(
      .WORD_MAX (WORD_MAX),
      .ADDR_W   (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .line_width (line_width_ff),
      .head       (head),
      .not_empty  (not_empty),
      .pop        (pop),
      .busy       (busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp        (rsp)
   );
endmodule
